>>> rtl/core/meta_log_latest_record_scan_defines.svh
// assertion helpers used by the checker file
`ifndef META_LOG_LATEST_RECORD_SCAN_DEFINES_SVH
`define META_LOG_LATEST_RECORD_SCAN_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define MLLRS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: check failed");

// implication checked on every rising clock edge outside reset
`define MLLRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	`MLLRS_ASSERT(label, clk, rst_n, (ante) |-> (cons))

`endif

>>> rtl/core/mllrs_pkg.sv
package mllrs_pkg;

	// record words
	localparam logic [31:0] LogMagic   = 32'h4154_4D43;
	localparam logic [31:0] ErasedWord = 32'hFFFF_FFFF;
	localparam logic [7:0]  SlotCharA  = 8'h41;
	localparam logic [7:0]  SlotCharB  = 8'h42;

	// reflected crc-32, init and final xor all ones
	localparam logic [31:0] CrcPoly    = 32'hEDB8_8320;
	localparam logic [31:0] CrcAllOnes = 32'hFFFF_FFFF;

	// one input request: a 16-byte log record plus the last mark
	typedef struct packed {
		logic [31:0] rec_magic;
		logic [31:0] rec_sequence;
		logic [31:0] rec_slot_word;
		logic [31:0] rec_crc;
		logic        last_record;
	} rec_t;

	// one result request, given on the last record of a scan
	typedef struct packed {
		logic        found;
		logic        slot_is_b;
		logic [31:0] best_sequence;
	} res_t;

	// feed one little-endian word into the crc, bit by bit from the lsb;
	// linear in its inputs, so it reduces to a fixed xor network
	function automatic logic [31:0] crc_feed_word(input logic [31:0] crc_in,
			input logic [31:0] word);
		logic [31:0] crc;
		crc = crc_in;
		for (int i = 0; i < 32; i++) begin
			crc = (crc >> 1) ^ (CrcPoly & {32{crc[0] ^ word[i]}});
		end
		return crc;
	endfunction

	// crc state after the magic word; a record is only checked when its
	// magic matches, so the first four bytes are a constant
	localparam logic [31:0] CrcAfterMagic = crc_feed_word(CrcAllOnes, LogMagic);

	// crc of the twelve record bytes: magic, sequence, slot word
	function automatic logic [31:0] record_crc(input logic [31:0] sequence_word,
			input logic [31:0] slot_word);
		return crc_feed_word(crc_feed_word(CrcAfterMagic, sequence_word), slot_word)
			^ CrcAllOnes;
	endfunction

endpackage

>>> rtl/core/meta_log_latest_record_scan.sv
// the result of a last record passes the record register and then the result register
// throughput: one record per cycle while no last record waits; the crc check and sequence compare sit in one
// stage between the record register and the scan state / result register
// a last record waits in the record register only while a result is still untaken
// reset (arst_n low, asynchronous): pipeline empty, scan state cleared, no result
module meta_log_latest_record_scan (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rec_valid,
	output logic               rec_ready,
	input  mllrs_pkg::rec_t    rec_data,
	output logic               res_valid,
	input  logic               res_ready,
	output mllrs_pkg::res_t    res_data
);

	logic              valid_s1;
	mllrs_pkg::rec_t   rec_s1;
	logic              fire_s1;

	logic              stopped_q;
	logic              have_best_q;
	logic [31:0]       best_seq_q;
	logic              best_slot_q;

	logic              res_valid_q;
	mllrs_pkg::res_t   res_q;

	logic [7:0]        slot_char;
	logic [31:0]       crc_calc;
	logic              is_erased;
	logic              rec_ok;
	logic              take;
	logic              have_n;
	logic [31:0]       seq_n;
	logic              slot_n;

	// a last record needs the result register free or draining
	assign fire_s1   = valid_s1 && (!rec_s1.last_record || !res_valid_q || res_ready);
	assign rec_ready = !valid_s1 || fire_s1;

	// record register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rec_ready) begin
			valid_s1 <= rec_valid;
		end
	end

	// record register: payload
	always_ff @(posedge clk) begin
		if (rec_valid && rec_ready) begin
			rec_s1 <= rec_data;
		end
	end

	// record check and best-record selection
	always_comb begin
		slot_char = rec_s1.rec_slot_word[7:0];
		crc_calc  = mllrs_pkg::record_crc(rec_s1.rec_sequence, rec_s1.rec_slot_word);
		is_erased = (rec_s1.rec_magic == mllrs_pkg::ErasedWord);
		rec_ok    = (rec_s1.rec_magic == mllrs_pkg::LogMagic)
			&& (crc_calc == rec_s1.rec_crc)
			&& ((slot_char == mllrs_pkg::SlotCharA) || (slot_char == mllrs_pkg::SlotCharB));
		take      = !stopped_q && rec_ok
			&& (!have_best_q || (rec_s1.rec_sequence > best_seq_q));
		have_n    = have_best_q || take;
		seq_n     = take ? rec_s1.rec_sequence : best_seq_q;
		slot_n    = take ? (slot_char == mllrs_pkg::SlotCharB) : best_slot_q;
	end

	// scan state, cleared after the last record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stopped_q   <= 1'b0;
			have_best_q <= 1'b0;
			best_seq_q  <= '0;
			best_slot_q <= 1'b0;
		end else if (fire_s1) begin
			if (rec_s1.last_record) begin
				stopped_q   <= 1'b0;
				have_best_q <= 1'b0;
				best_seq_q  <= '0;
				best_slot_q <= 1'b0;
			end else begin
				stopped_q   <= stopped_q || is_erased;
				have_best_q <= have_n;
				best_seq_q  <= seq_n;
				best_slot_q <= slot_n;
			end
		end
	end

	// result register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire_s1 && rec_s1.last_record) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result register: payload
	always_ff @(posedge clk) begin
		if (fire_s1 && rec_s1.last_record) begin
			res_q.found         <= have_n;
			res_q.slot_is_b     <= have_n && slot_n;
			res_q.best_sequence <= have_n ? seq_n : '0;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

>>> rtl/core/mllrs_checker.sv
`include "meta_log_latest_record_scan_defines.svh"

module mllrs_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rec_valid,
	input  logic               rec_ready,
	input  mllrs_pkg::rec_t    rec_data,
	input  logic               res_valid,
	input  logic               res_ready,
	input  mllrs_pkg::res_t    res_data
);

	// a stalled result holds
	`MLLRS_ASSERT_IMP(a_res_hold, clk, arst_n, res_valid && !res_ready, ##1 res_valid)
	`MLLRS_ASSERT_IMP(a_res_stable, clk, arst_n, res_valid && !res_ready, ##1 $stable(res_data))

	// an empty scan reports zeros
	`MLLRS_ASSERT_IMP(a_empty_zero, clk, arst_n, res_valid && !res_data.found, !res_data.slot_is_b && (res_data.best_sequence == 32'd0))

	// a new result must trace back to an accepted last record request
	`MLLRS_ASSERT_IMP(a_res_from_last, clk, arst_n, $rose(res_valid), $past(rec_valid && rec_ready && rec_data.last_record, 2))

	// records flow whenever no result is pending
	`MLLRS_ASSERT_IMP(a_ready_when_idle, clk, arst_n, !res_valid, rec_ready)

endmodule

bind meta_log_latest_record_scan mllrs_checker u_mllrs_checker (.*);
